/* hdl/hcx_pkg.sv */
// shared types, constants and the mod-26 reduction of the 2x2 hill cipher encryptor
package hcx_pkg;

   localparam int LETTER_W = 5;
   localparam int PROD_W   = 2 * LETTER_W;
   localparam int SUM_W    = PROD_W + 1;

   localparam logic [LETTER_W-1:0] HILL_MOD = 5'd26;
   localparam logic [LETTER_W-1:0] HILL_PAD = 5'd23;

   // reciprocal of 26 scaled by 2^16, exact for every sum of two 5x5 products
   localparam int          RECIP_SHIFT = 16;
   localparam logic [11:0] RECIP_26    = 12'd2521;
   localparam int          RECIP_W     = 12;
   localparam int          QUOT_W      = 7;

   typedef enum logic [1:0] {
      CSR_KEY_R0C0 = 2'd0,
      CSR_KEY_R0C1 = 2'd1,
      CSR_KEY_R1C0 = 2'd2,
      CSR_KEY_R1C1 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                end_of_message;
   } req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] cipher_letter;
      logic                last_out;
   } rsp_type;

   typedef struct packed {
      logic [LETTER_W-1:0] p0;
      logic [LETTER_W-1:0] p1;
      logic                last;
   } pair_type;

   typedef struct packed {
      logic [LETTER_W-1:0] r0c0;
      logic [LETTER_W-1:0] r0c1;
      logic [LETTER_W-1:0] r1c0;
      logic [LETTER_W-1:0] r1c1;
   } key_type;

   function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] sum);
      logic [SUM_W+RECIP_W-1:0] scaled;
      logic [QUOT_W-1:0]        quot;
      logic [SUM_W-1:0]         rem;
      scaled = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP_26};
      quot   = scaled[RECIP_SHIFT +: QUOT_W];
      rem    = sum - SUM_W'({quot, 4'b0} + {1'b0, quot, 3'b0} + {quot, 1'b0});
      return rem[LETTER_W-1:0];
   endfunction

endpackage

/* hdl/hcx_front.sv */
// front end: pairs up incoming letters and pads a lone last letter with x
module hcx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  hcx_pkg::req_type  req_data,
   input  logic              pair_full,
   output logic              req_full,
   output logic              pair_push,
   output hcx_pkg::pair_type pair_data
);
   import hcx_pkg::*;

   logic [LETTER_W-1:0] held_ff;
   logic [LETTER_W-1:0] held_in;
   logic                half_ff;
   logic                half_in;
   logic                accept;

   assign req_full = pair_full;
   assign accept   = req_push && !pair_full;

   always_comb begin
      held_in   = held_ff;
      half_in   = half_ff;
      pair_push = 1'b0;
      pair_data = '{p0: held_ff, p1: req_data.letter, last: req_data.end_of_message};
      if (accept) begin
         if (half_ff) begin
            pair_push = 1'b1;
            half_in   = 1'b0;
         end else if (req_data.end_of_message) begin
            pair_push = 1'b1;
            pair_data = '{p0: req_data.letter, p1: HILL_PAD, last: 1'b1};
         end else begin
            held_in = req_data.letter;
            half_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 1'b0;
         held_ff <= '0;
      end else begin
         half_ff <= half_in;
         held_ff <= held_in;
      end
   end

endmodule

/* hdl/hcx_pair_queue.sv */
// two-entry queue of letter pairs between front and back
module hcx_pair_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hcx_pkg::pair_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output hcx_pkg::pair_type pop_data
);
   import hcx_pkg::*;

   pair_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/hcx_back.sv */
// back end: one key row per unstalled cycle, dot product mod 26, result queue
module hcx_back #(
   parameter int RSP_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  hcx_pkg::key_type  key,
   input  logic              pair_empty,
   input  hcx_pkg::pair_type pair_data,
   output logic              pair_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output hcx_pkg::rsp_type  rsp_data
);
   import hcx_pkg::*;

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RSP_DEPTH - 1);
   localparam logic [CNT_W:0]   DEPTH_C  = (CNT_W+1)'(RSP_DEPTH);

   logic                row_ff;
   logic                row_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [SUM_W-1:0]    s1_sum_ff;
   logic [SUM_W-1:0]    s1_sum_in;
   logic                s1_last_ff;
   logic                s1_last_in;
   logic                issue;
   logic [LETTER_W-1:0] ka;
   logic [LETTER_W-1:0] kb;
   logic [PROD_W-1:0]   prod_a;
   logic [PROD_W-1:0]   prod_b;

   rsp_type             mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                do_pop;
   rsp_type             wr_data;

   // credit check counts the result still in the product stage
   assign issue = !pair_empty &&
                  (({1'b0, count_ff} + {{CNT_W{1'b0}}, s1_valid_ff}) < DEPTH_C);
   assign pair_pop = issue && row_ff;

   always_comb begin
      ka          = row_ff ? key.r1c0 : key.r0c0;
      kb          = row_ff ? key.r1c1 : key.r0c1;
      prod_a      = {{LETTER_W{1'b0}}, ka} * {{LETTER_W{1'b0}}, pair_data.p0};
      prod_b      = {{LETTER_W{1'b0}}, kb} * {{LETTER_W{1'b0}}, pair_data.p1};
      s1_sum_in   = {1'b0, prod_a} + {1'b0, prod_b};
      s1_last_in  = row_ff && pair_data.last;
      s1_valid_in = issue;
      row_in      = issue ? !row_ff : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_sum_ff  <= s1_sum_in;
         s1_last_ff <= s1_last_in;
      end
   end

   assign wr_data   = '{cipher_letter: mod26(s1_sum_ff), last_out: s1_last_ff};
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (s1_valid_ff) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + {{(CNT_W-1){1'b0}}, s1_valid_ff}
                          - {{(CNT_W-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hdl/hill_cipher_2x2_encrypt.sv */
// top level of the 2x2 hill cipher encryptor: key registers, front, pair queue, back
//
//   channel   ports                              direction  moves
//   request   req_push / req_full / req_data     in         one plaintext letter
//   response  rsp_pop / rsp_empty / rsp_data     out        one cipher letter
//   csr       csr_valid / csr_ready / csr_index  in         one key element write
//             csr_wdata
//
// one letter is taken per cycle while req_full is low; a pair gives two cipher letters,
// one per unstalled cycle, set by the single key-row multiply-add unit in the back end
// the request that completes a pair goes into the pair queue, its row-0 sum into the
// product register and then, reduced mod 26, into the response queue; row 1 follows
// synchronous reset clears the held letter, both queues and the key registers
// req_full follows the pair queue only, so a stalled rsp side backs up through it
module hill_cipher_2x2_encrypt #(
   parameter int RSP_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   req_push,
   input  hcx_pkg::req_type       req_data,
   output logic                   req_full,
   // response side
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output hcx_pkg::rsp_type       rsp_data,
   // key register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  hcx_pkg::csr_index_type csr_index,
   input  logic [4:0]             csr_wdata
);
   import hcx_pkg::*;

   key_type  key_ff;
   key_type  key_in;
   logic     pair_push;
   pair_type front_pair;
   logic     pair_full;
   logic     pair_empty;
   logic     pair_pop;
   pair_type queue_pair;

   // key writes always land at once
   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_R0C0: key_in.r0c0 = csr_wdata;
            CSR_KEY_R0C1: key_in.r0c1 = csr_wdata;
            CSR_KEY_R1C0: key_in.r1c0 = csr_wdata;
            CSR_KEY_R1C1: key_in.r1c1 = csr_wdata;
            default:      key_in      = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // pairing of letters and padding of a lone last letter
   hcx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .pair_full (pair_full),
      .req_full  (req_full),
      .pair_push (pair_push),
      .pair_data (front_pair)
   );

   // decouples pairing from the row-by-row sequencing of the back end
   hcx_pair_queue u_pair_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pair_push),
      .push_data (front_pair),
      .pop       (pair_pop),
      .full      (pair_full),
      .empty     (pair_empty),
      .pop_data  (queue_pair)
   );

   // row 0 then row 1 of the key against each pair, results into the response queue
   hcx_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .key        (key_ff),
      .pair_empty (pair_empty),
      .pair_data  (queue_pair),
      .pair_pop   (pair_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/hill_cipher_2x2_encrypt_tb.sv */
// self-checking testbench of the 2x2 hill cipher encryptor, with its own pair predictor
module hill_cipher_2x2_encrypt_tb;
   import hcx_pkg::*;

   localparam int RESET_CYCLES  = 8;
   // well past the time a pair takes from request to response
   localparam int DRAIN_CYCLES  = 12;
   localparam int ITEMS_PER_KEY = 156;
   localparam int MAX_REPORTS   = 10;
   localparam int TIMEOUT_UNITS = 12 * 200000;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_push  = 1'b0;
   req_type       req_data  = '0;
   logic          req_full;
   logic          rsp_pop   = 1'b0;
   logic          rsp_empty;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_KEY_R0C0;
   logic [4:0]    csr_wdata = '0;

   // predictor state: key matrix, held first letter of a pair and its flag
   key_type       key_copy  = '0;
   logic [4:0]    held_copy = '0;
   logic          half_copy = 1'b0;

   // cipher letters still owed by the block, oldest first
   rsp_type       cipher_due[$];

   int            mismatch_count = 0;
   int            send_idle_pct  = 0;
   int            rsp_stall_pct  = 0;

   hill_cipher_2x2_encrypt uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // one row of the key times the pair, reduced mod 26; keys and letters
   // above 25 enter the product as they are
   function automatic logic [4:0] row_dot(input logic [4:0] ka, input logic [4:0] kb,
                                          input logic [4:0] pa, input logic [4:0] pb);
      return 5'((int'(ka) * int'(pa) + int'(kb) * int'(pb)) % int'(HILL_MOD));
   endfunction

   task automatic queue_pair(input logic [4:0] p0, input logic [4:0] p1, input logic last);
      rsp_type c;
      c.cipher_letter  = row_dot(key_copy.r0c0, key_copy.r0c1, p0, p1);
      c.last_out       = 1'b0;
      cipher_due.push_back(c);
      c.cipher_letter  = row_dot(key_copy.r1c0, key_copy.r1c1, p0, p1);
      c.last_out       = last;
      cipher_due.push_back(c);
   endtask

   task automatic encipher_letter(input req_type item);
      if (half_copy) begin
         // second letter closes the pair, its end flag goes on the second cipher letter
         queue_pair(held_copy, item.letter, item.end_of_message);
         half_copy = 1'b0;
      end else if (item.end_of_message) begin
         // message ends on a lone letter: pad the pair with x
         queue_pair(item.letter, HILL_PAD, 1'b1);
      end else begin
         held_copy = item.letter;
         half_copy = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- response side

   // pop at random per the current stall rate; changes on the falling edge
   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input rsp_type due_item,
                                  input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected letter %0d last %0b, got letter %0d last %0b", $time,
                  what, due_item.cipher_letter, due_item.last_out,
                  got.cipher_letter, got.last_out);
   endtask

   always @(posedge clock) begin : check_cipher
      rsp_type due_item;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (cipher_due.size() == 0) begin
            report_mismatch("cipher letter with none due", '0, rsp_data);
         end else begin
            due_item = cipher_due.pop_front();
            if (rsp_data.cipher_letter !== due_item.cipher_letter ||
                rsp_data.last_out !== due_item.last_out)
               report_mismatch("cipher mismatch", due_item, rsp_data);
         end
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_letter(input logic [4:0] letter, input logic eom);
      req_type item;
      item.letter         = letter;
      item.end_of_message = eom;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push = 1'b0;
      end
      @(negedge clock);
      req_push = 1'b1;
      req_data = item;
      do @(posedge clock); while (req_full);
      encipher_letter(item);
   endtask

   // drop the request, let every owed letter out, then allow for a pair still in flight
   task automatic settle();
      @(negedge clock);
      req_push = 1'b0;
      while (cipher_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input csr_index_type idx, input logic [4:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY_R0C0: key_copy.r0c0 = value;
         CSR_KEY_R0C1: key_copy.r0c1 = value;
         CSR_KEY_R1C0: key_copy.r1c0 = value;
         CSR_KEY_R1C1: key_copy.r1c1 = value;
         default:      key_copy      = key_copy;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_key(input logic [4:0] k00, input logic [4:0] k01,
                           input logic [4:0] k10, input logic [4:0] k11);
      settle();
      write_key(CSR_KEY_R0C0, k00);
      write_key(CSR_KEY_R0C1, k01);
      write_key(CSR_KEY_R1C0, k10);
      write_key(CSR_KEY_R1C1, k11);
   endtask

   // mostly real letters, now and then an out-of-range index
   function automatic logic [4:0] rand_letter();
      if ($urandom_range(15) == 0)
         return 5'($urandom_range(31, 26));
      return 5'($urandom_range(25));
   endfunction

   // key elements lean towards the edges: zero, z and the top of the field
   function automatic logic [4:0] rand_key_value();
      case ($urandom_range(9))
         0:       return 5'd0;
         1:       return 5'd25;
         2:       return 5'd31;
         default: return 5'($urandom_range(31));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // key registers come out of reset as zero, so every cipher letter is zero
   task automatic test_reset_key();
      send_letter(5'd7, 1'b0);
      send_letter(5'd19, 1'b0);
      send_letter(5'd31, 1'b1);
   endtask

   task automatic test_pairs_and_padding();
      load_key(5'd3, 5'd3, 5'd2, 5'd5);
      // plain pair, then a pair that ends the message on its second letter
      send_letter(5'd0, 1'b0);
      send_letter(5'd25, 1'b0);
      send_letter(5'd25, 1'b0);
      send_letter(5'd31, 1'b1);
      // lone last letters, padded with x
      send_letter(5'd31, 1'b1);
      send_letter(5'd0, 1'b1);
      // held letter waits through a long quiet spell for its partner
      send_letter(5'd13, 1'b0);
      @(negedge clock);
      req_push = 1'b0;
      repeat (20) @(posedge clock);
      send_letter(5'd4, 1'b1);
   endtask

   task automatic test_key_extremes();
      load_key(5'd31, 5'd31, 5'd31, 5'd31);
      send_letter(5'd31, 1'b0);
      send_letter(5'd31, 1'b0);
      send_letter(5'd26, 1'b1);
      load_key(5'd25, 5'd25, 5'd25, 5'd25);
      send_letter(5'd25, 1'b0);
      send_letter(5'd25, 1'b1);
      send_letter(5'd1, 1'b1);
      load_key(5'd0, 5'd31, 5'd25, 5'd1);
      send_letter(5'd1, 1'b0);
      send_letter(5'd2, 1'b1);
   endtask

   // messages of random length under two random keys; a few carry a stray end
   // flag and a few never end, running into the next message
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int sent;
      int len;
      bit open_ended;
      logic eom;
      rsp_stall_pct = stall_pct;
      repeat (2) begin
         load_key(rand_key_value(), rand_key_value(), rand_key_value(), rand_key_value());
         send_idle_pct = idle_pct;
         sent = 0;
         while (sent < ITEMS_PER_KEY) begin
            len        = $urandom_range(1, 9);
            open_ended = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++) begin
               eom = (i == len - 1) && !open_ended;
               if ($urandom_range(11) == 0)
                  eom = 1'($urandom_range(1));
               send_letter(rand_letter(), eom);
               sent++;
            end
         end
         send_idle_pct = 0;
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_key();
      test_pairs_and_padding();
      test_key_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(48, 0);
      test_random_traffic(0, 48);
      test_random_traffic(37, 37);

      rsp_stall_pct = 0;
      settle();
      if (mismatch_count == 0 && cipher_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
